### rtl/psd_pkg.sv
package psd_pkg;

  localparam int CoordW     = 16;
  localparam int DiffW      = CoordW + 1;
  localparam int LenW       = 33;
  localparam int QuoW       = 16;
  localparam int DivStages  = QuoW;
  localparam int TW         = QuoW + 1;
  localparam int MagW       = 33;
  localparam int SqW        = 52;
  localparam int RootW      = SqW / 2;
  localparam int SqrtStages = RootW;
  localparam int RemW       = RootW + 3;
  localparam int DistW      = 25;

  typedef enum logic [1:0] {
    TSEL_ZERO,
    TSEL_ONE,
    TSEL_DIV
  } tsel_t;

  typedef struct packed {
    logic signed [DiffW-1:0] dx;
    logic signed [DiffW-1:0] dy;
    logic signed [DiffW-1:0] wx;
    logic signed [DiffW-1:0] wy;
    tsel_t                   tsel;
  } side_t;

endpackage

### rtl/psd_div.sv
module psd_div
  import psd_pkg::*;
(
  input  logic            clk,
  input  logic            rst,
  input  logic            up_valid,
  output logic            up_stall,
  input  logic [LenW-1:0] rem_in,
  input  logic [LenW-1:0] len_in,
  input  side_t           side_in,
  output logic            dn_valid,
  input  logic            dn_stall,
  output logic [QuoW-1:0] quo,
  output side_t           side_out
);

  localparam int N = DivStages;

  logic [N-1:0]    v;
  logic [N:0]      en;
  logic [LenW-1:0] rem [N];
  logic [LenW-1:0] len [N];
  logic [QuoW-1:0] q   [N];
  side_t           sd  [N];

  assign en[N]    = !dn_stall;
  assign up_stall = !en[0];

  for (genvar k = 0; k < N; k++) begin : g_stage
    logic            v_p;
    logic [LenW-1:0] rem_p;
    logic [LenW-1:0] len_p;
    logic [QuoW-1:0] q_p;
    side_t           sd_p;
    logic [LenW:0]   r2;
    logic            ge;
    logic [LenW:0]   rn;

    if (k == 0) begin : g_first
      assign v_p   = up_valid;
      assign rem_p = rem_in;
      assign len_p = len_in;
      assign q_p   = '0;
      assign sd_p  = side_in;
    end else begin : g_rest
      assign v_p   = v[k-1];
      assign rem_p = rem[k-1];
      assign len_p = len[k-1];
      assign q_p   = q[k-1];
      assign sd_p  = sd[k-1];
    end

    assign en[k] = !v[k] || en[k+1];

    // one restoring step, remainder stays below the divisor
    always_comb begin
      r2 = {rem_p, 1'b0};
      ge = r2 >= {1'b0, len_p};
      rn = ge ? r2 - {1'b0, len_p} : r2;
    end

    always_ff @(posedge clk) begin
      if (rst) begin
        v[k] <= 1'b0;
      end else if (en[k]) begin
        v[k] <= v_p;
      end
      if (en[k]) begin
        rem[k] <= rn[LenW-1:0];
        len[k] <= len_p;
        q[k]   <= {q_p[QuoW-2:0], ge};
        sd[k]  <= sd_p;
      end
    end
  end

  assign dn_valid = v[N-1];
  assign quo      = q[N-1];
  assign side_out = sd[N-1];

`ifndef SYNTHESIS
  a_rem_below_len: assert property (@(posedge clk) disable iff (rst)
    v[N-1] && sd[N-1].tsel == TSEL_DIV |-> rem[N-1] < len[N-1])
    else $error("divider remainder not below divisor");
`endif

endmodule

### rtl/psd_sqrt.sv
module psd_sqrt
  import psd_pkg::*;
(
  input  logic             clk,
  input  logic             rst,
  input  logic             up_valid,
  output logic             up_stall,
  input  logic [SqW-1:0]   radicand,
  output logic             dn_valid,
  input  logic             dn_stall,
  output logic [RootW-1:0] root_out
);

  localparam int N = SqrtStages;

  logic [N-1:0]     v;
  logic [N:0]       en;
  logic [SqW-1:0]   n    [N];
  logic [RemW-1:0]  rem  [N];
  logic [RootW-1:0] root [N];

  assign en[N]    = !dn_stall;
  assign up_stall = !en[0];

  for (genvar k = 0; k < N; k++) begin : g_stage
    logic             v_p;
    logic [SqW-1:0]   n_p;
    logic [RemW-1:0]  rem_p;
    logic [RootW-1:0] root_p;
    logic [RemW-1:0]  rem_sh;
    logic [RemW-1:0]  trial;
    logic             ge;

    if (k == 0) begin : g_first
      assign v_p    = up_valid;
      assign n_p    = radicand;
      assign rem_p  = '0;
      assign root_p = '0;
    end else begin : g_rest
      assign v_p    = v[k-1];
      assign n_p    = n[k-1];
      assign rem_p  = rem[k-1];
      assign root_p = root[k-1];
    end

    assign en[k] = !v[k] || en[k+1];

    // bring down two radicand bits, try root*4+1
    always_comb begin
      rem_sh = {rem_p[RemW-3:0], n_p[SqW-1 -: 2]};
      trial  = RemW'({root_p, 2'b01});
      ge     = rem_sh >= trial;
    end

    always_ff @(posedge clk) begin
      if (rst) begin
        v[k] <= 1'b0;
      end else if (en[k]) begin
        v[k] <= v_p;
      end
      if (en[k]) begin
        n[k]    <= {n_p[SqW-3:0], 2'b00};
        rem[k]  <= ge ? rem_sh - trial : rem_sh;
        root[k] <= {root_p[RootW-2:0], ge};
      end
    end
  end

  assign dn_valid = v[N-1];
  assign root_out = root[N-1];

`ifndef SYNTHESIS
  a_root_range: assert property (@(posedge clk) disable iff (rst)
    v[N-1] |-> root[N-1][RootW-1] == 1'b0)
    else $error("square root exceeds distance range");
`endif

endmodule

### rtl/point_to_segment_distance_core.sv
// pipeline: 49 register stages; seg_distance comes from the last square-root stage
// throughput: one request per cycle; every stage holds its item under stall
// the divider is 16 one-bit stages, the square root 26 two-bit stages
// reset (rst, synchronous) clears all stage valid bits; no data is reset
module point_to_segment_distance_core
  import psd_pkg::*;
(
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    valid,
  output logic                    stall,
  input  logic signed [CoordW-1:0] point_x,
  input  logic signed [CoordW-1:0] point_y,
  input  logic signed [CoordW-1:0] start_x,
  input  logic signed [CoordW-1:0] start_y,
  input  logic signed [CoordW-1:0] end_x,
  input  logic signed [CoordW-1:0] end_y,
  output logic                    dist_valid,
  input  logic                    dist_stall,
  output logic [DistW-1:0]        seg_distance
);

  // stage a: differences
  logic                    va, ena;
  logic signed [DiffW-1:0] a_dx, a_dy, a_wx, a_wy;
  // stage b: products
  logic                    vb, enb;
  logic signed [33:0]      b_xx, b_yy, b_xd, b_yd;
  logic signed [DiffW-1:0] b_dx, b_dy, b_wx, b_wy;
  // stage c: sums and case select
  logic                    vc, enc;
  logic [LenW-1:0]         c_rem, c_len;
  side_t                   c_side;
  logic signed [34:0]      len_sum, dot_sum;
  tsel_t                   tsel_next;
  // divider
  logic                    div_stall, div_valid, div_dn_stall;
  logic [QuoW-1:0]         div_q;
  side_t                   div_side;
  // stage d: t times direction
  logic                    vd, end_en;
  logic signed [34:0]      d_px, d_py;
  logic signed [DiffW-1:0] d_wx, d_wy;
  logic [TW-1:0]           t_val;
  // stage e: offset magnitudes
  logic                    ve, ene;
  logic [MagW-1:0]         e_mx, e_my;
  logic signed [34:0]      ex, ey;
  // stage f: partial squares
  logic                    vf, enf;
  logic [33:0]             f_hhx, f_hhy;
  logic [32:0]             f_hlx, f_hly;
  logic [31:0]             f_llx, f_lly;
  // stage g: scaled sum of squares
  logic                    vg, eng;
  logic [SqW-1:0]          g_s;
  logic [34:0]             hh_sum;
  logic [33:0]             hl_sum;
  logic [32:0]             ll_sum;
  // square root
  logic                    sq_stall;
  logic [RootW-1:0]        root;

  assign ena   = !va || enb;
  assign enb   = !vb || enc;
  assign enc   = !vc || !div_stall;
  assign stall = !ena;

  assign div_dn_stall = !end_en;
  assign end_en = !vd || ene;
  assign ene    = !ve || enf;
  assign enf    = !vf || eng;
  assign eng    = !vg || !sq_stall;

  always_comb begin
    len_sum = 35'(b_xx) + 35'(b_yy);
    dot_sum = 35'(b_xd) + 35'(b_yd);
    if (len_sum == '0 || dot_sum <= 0) begin
      tsel_next = TSEL_ZERO;
    end else if (dot_sum >= len_sum) begin
      tsel_next = TSEL_ONE;
    end else begin
      tsel_next = TSEL_DIV;
    end
  end

  always_comb begin
    case (div_side.tsel)
      TSEL_ZERO: t_val = '0;
      TSEL_ONE:  t_val = TW'(1) << QuoW;
      TSEL_DIV:  t_val = {1'b0, div_q};
      default:   t_val = '0;
    endcase
  end

  always_comb begin
    ex = d_px - $signed({19'(d_wx), 16'h0000});
    ey = d_py - $signed({19'(d_wy), 16'h0000});
  end

  always_comb begin
    hh_sum = 35'(f_hhx) + 35'(f_hhy);
    hl_sum = 34'(f_hlx) + 34'(f_hly);
    ll_sum = 33'(f_llx) + 33'(f_lly);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      va <= 1'b0;
      vb <= 1'b0;
      vc <= 1'b0;
      vd <= 1'b0;
      ve <= 1'b0;
      vf <= 1'b0;
      vg <= 1'b0;
    end else begin
      if (ena) va <= valid;
      if (enb) vb <= va;
      if (enc) vc <= vb;
      if (end_en) vd <= div_valid;
      if (ene) ve <= vd;
      if (enf) vf <= ve;
      if (eng) vg <= vf;
    end
  end

  always_ff @(posedge clk) begin
    if (ena) begin
      a_dx <= DiffW'(end_x) - DiffW'(start_x);
      a_dy <= DiffW'(end_y) - DiffW'(start_y);
      a_wx <= DiffW'(point_x) - DiffW'(start_x);
      a_wy <= DiffW'(point_y) - DiffW'(start_y);
    end
    if (enb) begin
      b_xx <= a_dx * a_dx;
      b_yy <= a_dy * a_dy;
      b_xd <= a_wx * a_dx;
      b_yd <= a_wy * a_dy;
      b_dx <= a_dx;
      b_dy <= a_dy;
      b_wx <= a_wx;
      b_wy <= a_wy;
    end
    if (enc) begin
      c_len       <= len_sum[LenW-1:0];
      c_rem       <= (tsel_next == TSEL_DIV) ? dot_sum[LenW-1:0] : '0;
      c_side.dx   <= b_dx;
      c_side.dy   <= b_dy;
      c_side.wx   <= b_wx;
      c_side.wy   <= b_wy;
      c_side.tsel <= tsel_next;
    end
    if (end_en) begin
      d_px <= $signed({1'b0, t_val}) * div_side.dx;
      d_py <= $signed({1'b0, t_val}) * div_side.dy;
      d_wx <= div_side.wx;
      d_wy <= div_side.wy;
    end
    if (ene) begin
      e_mx <= ex[34] ? MagW'(-ex) : MagW'(ex);
      e_my <= ey[34] ? MagW'(-ey) : MagW'(ey);
    end
    if (enf) begin
      f_hhx <= e_mx[32:16] * e_mx[32:16];
      f_hhy <= e_my[32:16] * e_my[32:16];
      f_hlx <= e_mx[32:16] * e_mx[15:0];
      f_hly <= e_my[32:16] * e_my[15:0];
      f_llx <= e_mx[15:0] * e_mx[15:0];
      f_lly <= e_my[15:0] * e_my[15:0];
    end
    if (eng) begin
      // floor((mx^2 + my^2) / 2^16) from the split squares
      g_s <= (SqW'(hh_sum) << 16) + SqW'({hl_sum, 1'b0}) + SqW'(ll_sum[32:16]);
    end
  end

  psd_div u_div (
    .clk      (clk),
    .rst      (rst),
    .up_valid (vc),
    .up_stall (div_stall),
    .rem_in   (c_rem),
    .len_in   (c_len),
    .side_in  (c_side),
    .dn_valid (div_valid),
    .dn_stall (div_dn_stall),
    .quo      (div_q),
    .side_out (div_side)
  );

  psd_sqrt u_sqrt (
    .clk      (clk),
    .rst      (rst),
    .up_valid (vg),
    .up_stall (sq_stall),
    .radicand (g_s),
    .dn_valid (dist_valid),
    .dn_stall (dist_stall),
    .root_out (root)
  );

  assign seg_distance = root[DistW-1:0];

`ifndef SYNTHESIS
  a_empty_out_no_stall: assert property (@(posedge clk) disable iff (rst)
    !dist_valid |-> !stall)
    else $error("request stalled while output stage empty");
  a_reset_clears: assert property (@(posedge clk)
    $past(rst) |-> !dist_valid && !vd && !va)
    else $error("valid bit survived reset");
  a_out_held: assert property (@(posedge clk) disable iff (rst)
    dist_valid && dist_stall |=> dist_valid && $stable(seg_distance))
    else $error("stalled result changed");
`endif

endmodule

### bench/tb_point_to_segment_distance_core.sv
`timescale 1ns / 100ps

module tb_point_to_segment_distance_core;
  import psd_pkg::*;

  localparam int Latency = 49;
  localparam int WatchdogLimit = 20000;
  localparam int NoExpect = -1;

  typedef struct {
    logic signed [CoordW-1:0] px, py, ax, ay, bx, by;
    int                       want;
  } seg_query_t;

  logic clk;
  logic rst;
  logic valid;
  logic stall;
  logic signed [CoordW-1:0] point_x, point_y, start_x, start_y, end_x, end_y;
  logic dist_valid;
  logic dist_stall;
  logic [DistW-1:0] seg_distance;

  logic [DistW-1:0] dist_queue[$];
  int errors;
  int idle_cycles;
  int send_idle_pct;
  int recv_stall_pct;
  bit timed_out;

  point_to_segment_distance_core dut (
    .clk(clk), .rst(rst), .valid(valid), .stall(stall),
    .point_x(point_x), .point_y(point_y), .start_x(start_x),
    .start_y(start_y), .end_x(end_x), .end_y(end_y),
    .dist_valid(dist_valid), .dist_stall(dist_stall),
    .seg_distance(seg_distance)
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  function automatic logic [63:0] isqrt(logic [63:0] n);
    logic [63:0] res;
    logic [63:0] bitv;
    res = 0;
    bitv = 64'd1 << 62;
    while (bitv > n) bitv >>= 2;
    while (bitv != 0) begin
      if (n >= res + bitv) begin
        n -= res + bitv;
        res = (res >> 1) + bitv;
      end else begin
        res >>= 1;
      end
      bitv >>= 2;
    end
    return res;
  endfunction

  function automatic logic [DistW-1:0] segment_distance(
      logic signed [CoordW-1:0] px, py, ax, ay, bx, by);
    longint dx, dy, wx, wy, len2, dotp, t, ex, ey;
    logic [127:0] sq;
    dx = longint'(bx) - longint'(ax);
    dy = longint'(by) - longint'(ay);
    wx = longint'(px) - longint'(ax);
    wy = longint'(py) - longint'(ay);
    len2 = dx * dx + dy * dy;
    dotp = wx * dx + wy * dy;
    if (len2 == 0 || dotp <= 0) t = 0;
    else if (dotp >= len2) t = 65536;
    else t = (dotp * 65536) / len2;
    ex = t * dx - wx * 65536;
    ey = t * dy - wy * 65536;
    if (ex < 0) ex = -ex;
    if (ey < 0) ey = -ey;
    // ex^2+ey^2 fits in 67 bits, so square in 128 then drop 16
    sq = (128'(ex) * 128'(ex) + 128'(ey) * 128'(ey)) >> 16;
    return DistW'(isqrt(sq[63:0]));
  endfunction

  task automatic report_mismatch(string what);
    $display("mismatch: %s", what);
    errors++;
  endtask

  // result side: stall and check
  always @(posedge clk) begin
    if (rst) begin
      dist_stall <= 1'b0;
    end else begin
      if (dist_valid && !dist_stall) begin
        if (dist_queue.size() == 0) begin
          report_mismatch($sformatf("unexpected seg_distance %0d", seg_distance));
        end else begin
          logic [DistW-1:0] exp_dist;
          exp_dist = dist_queue.pop_front();
          if (seg_distance !== exp_dist)
            report_mismatch($sformatf("seg_distance got %0d expected %0d",
                                      seg_distance, exp_dist));
        end
      end
      dist_stall <= ($urandom_range(99) < recv_stall_pct);
    end
  end

  // watchdog on accepted traffic
  always @(posedge clk) begin
    if (rst || (valid && !stall) || (dist_valid && !dist_stall)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= WatchdogLimit && !timed_out) begin
      timed_out = 1'b1;
      $display("** point_to_segment_distance_core: FAILED **");
      $finish;
    end
  end

  // valid stays high after accept; an idle cycle or the caller drops it
  task automatic send_request(logic signed [CoordW-1:0] px, py, ax, ay, bx, by,
                              int exp_dist);
    logic [DistW-1:0] pred;
    while ($urandom_range(99) < send_idle_pct) begin
      valid <= 1'b0;
      @(posedge clk);
    end
    valid <= 1'b1;
    point_x <= px; point_y <= py; start_x <= ax;
    start_y <= ay; end_x <= bx; end_y <= by;
    pred = segment_distance(px, py, ax, ay, bx, by);
    if (exp_dist != NoExpect && pred != DistW'(exp_dist))
      report_mismatch($sformatf("table row disagrees with predictor: %0d vs %0d",
                                exp_dist, pred));
    dist_queue.push_back(exp_dist == NoExpect ? pred : DistW'(exp_dist));
    do @(posedge clk); while (stall);
  endtask

  function automatic logic signed [CoordW-1:0] rand_coord(int mode);
    case (mode)
      0: return CoordW'($urandom);
      1: return CoordW'($urandom_range(15)) - 16'sd8;
      2: return $urandom_range(1) ? 16'sh7fff : 16'sh8000;
      default: return CoordW'($urandom_range(400)) - 16'sd200;
    endcase
  endfunction

  task automatic drain();
    int waited;
    waited = 0;
    valid <= 1'b0;
    while (dist_queue.size() != 0) @(posedge clk);
    while (waited < Latency + 4) begin
      @(posedge clk);
      waited++;
    end
  endtask

  seg_query_t directed[] = '{
    // all at origin, zero-length segment
    '{0, 0, 0, 0, 0, 0, 0},
    // zero-length segment, distance to endpoint 3-4-5
    '{3, 4, 0, 0, 0, 0, 5 * 256},
    // point on segment
    '{5, 0, 0, 0, 10, 0, 0},
    // perpendicular above middle
    '{5, 7, 0, 0, 10, 0, 7 * 256},
    // projection before start
    '{-3, 4, 0, 0, 10, 0, 5 * 256},
    // projection past end
    '{13, 4, 0, 0, 10, 0, 5 * 256},
    // extreme corners, zero-length segment
    '{16'sh7fff, 16'sh7fff, 16'sh8000, 16'sh8000, 16'sh8000, 16'sh8000, 23726204},
    '{16'sh8000, 16'sh8000, 16'sh7fff, 16'sh7fff, 16'sh7fff, 16'sh7fff, 23726204},
    '{16'sh7fff, 16'sh8000, 16'sh8000, 16'sh7fff, 16'sh8000, 16'sh7fff, 23726204},
    // full-span segments, then smaller mixed segments
    '{16'sh7fff, 16'sh7fff, 16'sh8000, 16'sh8000, 16'sh7fff, 16'sh7fff, 0},
    '{16'sh7fff, 16'sh8000, 16'sh8000, 16'sh8000, 16'sh7fff, 16'sh7fff, NoExpect},
    '{0, 0, 16'sh8000, 16'sh7fff, 16'sh7fff, 16'sh8000, NoExpect},
    '{16'sh8000, 16'sh7fff, 16'sh8000, 16'sh8000, 16'sh7fff, 16'sh7fff, NoExpect},
    '{1, 2, 0, 0, 3, 7, NoExpect},
    '{-1, -1, 1, 1, -1, 1, NoExpect},
    '{100, -37, -200, 55, 321, 77, NoExpect},
    '{16'sh7fff, 0, 0, 0, 1, 0, NoExpect},
    '{0, 16'sh8000, 0, 0, 0, 16'sh7fff, NoExpect}
  };

  initial begin
    int phase;
    int mode;
    rst = 1'b1;
    valid = 1'b0;
    {point_x, point_y, start_x, start_y, end_x, end_y} = '0;
    errors = 0;
    send_idle_pct = 0;
    recv_stall_pct = 0;
    repeat (7) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    foreach (directed[i])
      send_request(directed[i].px, directed[i].py, directed[i].ax, directed[i].ay,
                   directed[i].bx, directed[i].by, directed[i].want);
    // hold off until the pipe is empty
    drain();

    for (phase = 0; phase < 5; phase++) begin
      case (phase)
        1: begin send_idle_pct = 65; recv_stall_pct = 0; end
        2: begin send_idle_pct = 0; recv_stall_pct = 65; end
        3: begin send_idle_pct = 36; recv_stall_pct = 36; end
        default: begin send_idle_pct = 0; recv_stall_pct = 0; end
      endcase
      repeat (300) begin
        mode = $urandom_range(3);
        send_request(rand_coord(mode), rand_coord(mode), rand_coord(mode),
                     rand_coord(mode), rand_coord(mode), rand_coord(mode), NoExpect);
      end
    end

    drain();
    if (errors == 0 && dist_queue.size() == 0)
      $display("** point_to_segment_distance_core: PASSED **");
    else
      $display("** point_to_segment_distance_core: FAILED **");
    $finish;
  end

endmodule

### sim.f
rtl/psd_pkg.sv
rtl/psd_div.sv
rtl/psd_sqrt.sv
rtl/point_to_segment_distance_core.sv
bench/tb_point_to_segment_distance_core.sv
